>>> hdl/tx_cal_bilinear_interp_defines.svh
// ---------------------------------------------------------------------------
// tx_cal_bilinear_interp_defines
// Assertion macros shared by the calibration lookup modules.
// ---------------------------------------------------------------------------
`ifndef TX_CAL_BILINEAR_INTERP_DEFINES_SVH
`define TX_CAL_BILINEAR_INTERP_DEFINES_SVH

// condition holds at every edge out of reset
`define CBI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CBI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cbi_pkg.sv
// ---------------------------------------------------------------------------
// cbi_pkg
// Shared constants and types of the transmit calibration lookup.
// ---------------------------------------------------------------------------
package cbi_pkg;

    // grid geometry
    localparam int POWER_ROWS = 101;
    localparam int FREQ_COLS  = 117;
    localparam int WORD_WIDTH = 24;
    localparam int GRID_SIZE  = POWER_ROWS * FREQ_COLS;
    localparam int ADDR_W     = 14;
    localparam int ROW_W      = $clog2(POWER_ROWS);
    localparam int COL_W      = $clog2(FREQ_COLS);

    // field widths
    localparam int OP_W    = 2;
    localparam int FREQ_W  = 13;
    localparam int PWR_W   = 16;
    localparam int VAL_W   = 24;
    localparam int DAC_W   = 8;
    localparam int RES_W   = 24;
    localparam int TF_W    = 6;
    localparam int S_W     = 9;
    localparam int WGT_W   = 14;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_ATT = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // frequency axis, MHz
    localparam int FREQ_BASE = 200;
    localparam int FREQ_STEP = 50;
    localparam int FREQ_MAX  = FREQ_BASE + FREQ_STEP * (FREQ_COLS - 1);

    // power axis, 1/256 dBm
    localparam int POWER_TOP = 15;
    localparam int PWR_HI    = POWER_TOP * 256;
    localparam int PWR_LO    = (POWER_TOP - (POWER_ROWS - 1)) * 256;

    // x / 50 as (x * FDIV_MULT) >> FDIV_SHIFT, exact for x below 2^13
    localparam int FDIV_SHIFT = 18;
    localparam int FDIV_MULT  = 5243;
    localparam int FPROD_W    = FREQ_W + 13;

    // u / 50 as (u * ODIV_MULT) >> ODIV_SHIFT, exact for u below 2^30
    localparam int               ODIV_SHIFT = 36;
    localparam logic [30:0]      ODIV_MULT  = 31'd1374389535;
    localparam int               ODIV_U_W   = 30;
    localparam int               ODIV_P_W   = 61;
    localparam logic signed [40:0] ODIV_BIAS = 41'sd419430400;

    // queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WR_ATT = 2'd0,
        KIND_WR_OFF = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    // one classified word handed from front to back
    typedef struct packed {
        kind_t                  kind;
        logic [ADDR_W-1:0]      addr;
        logic [WORD_WIDTH-1:0]  value;
        logic [TF_W-1:0]        tf;
        logic [S_W-1:0]         s;
    } entry_t;

endpackage

>>> hdl/cbi_front.sv
// ---------------------------------------------------------------------------
// cbi_front
// Accepts input words, drops writes out of range and unused codes, and
// turns lookups into a grid base address and the two axis distances.
// ---------------------------------------------------------------------------
module cbi_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cbi_pkg::OP_W-1:0]      op,
    input  logic [cbi_pkg::ADDR_W-1:0]    idx,
    input  logic [cbi_pkg::VAL_W-1:0]     val,
    input  logic [cbi_pkg::FREQ_W-1:0]    freq,
    input  logic signed [cbi_pkg::PWR_W-1:0] pwr,
    input  logic                          q_full,
    output logic                          q_push,
    output cbi_pkg::entry_t               q_entry
);

    logic                               a_valid_reg, a_valid_next;
    cbi_pkg::kind_t                     a_kind_reg;
    logic [cbi_pkg::ADDR_W-1:0]         a_addr_reg;
    logic [cbi_pkg::WORD_WIDTH-1:0]     a_value_reg;
    logic [cbi_pkg::FREQ_W-1:0]         a_x_reg;
    logic [cbi_pkg::FPROD_W-1:0]        a_prod_reg;
    logic [cbi_pkg::ROW_W-1:0]          a_r_reg;
    logic [cbi_pkg::S_W-1:0]            a_s_reg;

    logic                               accept, keep;
    cbi_pkg::kind_t                     kind;
    logic [cbi_pkg::FREQ_W-1:0]         f_cl, x;
    logic [cbi_pkg::FPROD_W-1:0]        prod;
    logic signed [cbi_pkg::PWR_W-1:0]   p_cl;
    logic signed [cbi_pkg::PWR_W:0]     pdiff;
    logic [14:0]                        pp;
    logic [15:0]                        pp_up;
    logic [cbi_pkg::ROW_W-1:0]          a_row, a_sel, r;
    logic [15:0]                        s_full;

    logic [cbi_pkg::FPROD_W-cbi_pkg::FDIV_SHIFT-1:0] c_raw;
    logic [cbi_pkg::COL_W-1:0]          c;
    logic [cbi_pkg::FREQ_W-1:0]         tf_full;
    logic [cbi_pkg::ADDR_W-1:0]         base;

    assign s_ready = !a_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = a_valid_reg && !q_full;

    // classify the word
    always_comb begin
        keep = 1'b0;
        kind = cbi_pkg::KIND_LOOKUP;
        if (op == cbi_pkg::OP_LOOKUP) begin
            keep = 1'b1;
        end else if (op == cbi_pkg::OP_WR_ATT) begin
            keep = (32'(idx) < cbi_pkg::GRID_SIZE);
            kind = cbi_pkg::KIND_WR_ATT;
        end else if (op == cbi_pkg::OP_WR_OFF) begin
            keep = (32'(idx) < cbi_pkg::GRID_SIZE);
            kind = cbi_pkg::KIND_WR_OFF;
        end
    end

    // clamp frequency, start the divide by the column step
    always_comb begin
        if (32'(freq) < cbi_pkg::FREQ_BASE) begin
            f_cl = cbi_pkg::FREQ_W'(cbi_pkg::FREQ_BASE);
        end else if (32'(freq) > cbi_pkg::FREQ_MAX) begin
            f_cl = cbi_pkg::FREQ_W'(cbi_pkg::FREQ_MAX);
        end else begin
            f_cl = freq;
        end
        x    = f_cl - cbi_pkg::FREQ_W'(cbi_pkg::FREQ_BASE);
        prod = cbi_pkg::FPROD_W'(x) * cbi_pkg::FPROD_W'(cbi_pkg::FDIV_MULT);
    end

    // clamp power, upper row by ceiling, distance below it
    always_comb begin
        if (32'(pwr) < cbi_pkg::PWR_LO) begin
            p_cl = cbi_pkg::PWR_W'(cbi_pkg::PWR_LO);
        end else if (32'(pwr) > cbi_pkg::PWR_HI) begin
            p_cl = cbi_pkg::PWR_W'(cbi_pkg::PWR_HI);
        end else begin
            p_cl = pwr;
        end
        pdiff  = (cbi_pkg::PWR_W+1)'(p_cl) - (cbi_pkg::PWR_W+1)'(cbi_pkg::PWR_LO);
        pp     = pdiff[14:0];
        pp_up  = 16'(pp) + 16'd255;
        a_row  = cbi_pkg::ROW_W'(pp_up[15:8]);
        a_sel  = (a_row == '0) ? cbi_pkg::ROW_W'(1) : a_row;
        r      = cbi_pkg::ROW_W'(cbi_pkg::POWER_ROWS - 1) - a_sel;
        s_full = {1'b0, a_sel, 8'd0} - 16'(pp);
    end

    // stage A control
    always_comb begin
        a_valid_next = a_valid_reg;
        if (q_push) begin
            a_valid_next = 1'b0;
        end
        if (accept && keep) begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_kind_reg  <= kind;
            a_addr_reg  <= idx;
            a_value_reg <= val[cbi_pkg::WORD_WIDTH-1:0];
            a_x_reg     <= x;
            a_prod_reg  <= prod;
            a_r_reg     <= r;
            a_s_reg     <= s_full[cbi_pkg::S_W-1:0];
        end
    end

    // lower column, column distance, flat base address
    always_comb begin
        c_raw = a_prod_reg[cbi_pkg::FPROD_W-1:cbi_pkg::FDIV_SHIFT];
        if (32'(c_raw) > cbi_pkg::FREQ_COLS - 2) begin
            c = cbi_pkg::COL_W'(cbi_pkg::FREQ_COLS - 2);
        end else begin
            c = cbi_pkg::COL_W'(c_raw);
        end
        tf_full = a_x_reg - cbi_pkg::FREQ_W'(c) * cbi_pkg::FREQ_W'(cbi_pkg::FREQ_STEP);
        base    = cbi_pkg::ADDR_W'(a_r_reg) * cbi_pkg::ADDR_W'(cbi_pkg::FREQ_COLS)
                  + cbi_pkg::ADDR_W'(c);
    end

    always_comb begin
        q_entry.kind  = a_kind_reg;
        q_entry.addr  = (a_kind_reg == cbi_pkg::KIND_LOOKUP) ? base : a_addr_reg;
        q_entry.value = a_value_reg;
        q_entry.tf    = tf_full[cbi_pkg::TF_W-1:0];
        q_entry.s     = a_s_reg;
    end

endmodule

>>> hdl/cbi_queue.sv
// ---------------------------------------------------------------------------
// cbi_queue
// Short register queue between the front and the back.
// ---------------------------------------------------------------------------
`include "tx_cal_bilinear_interp_defines.svh"

module cbi_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cbi_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cbi_pkg::entry_t  head_entry
);

    cbi_pkg::entry_t               slot_reg [cbi_pkg::QDEPTH];
    logic [cbi_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cbi_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cbi_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == cbi_pkg::QCNT_W'(cbi_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CBI_ASSERT_ALWAYS(a_q_count_bound, count_reg <= cbi_pkg::QCNT_W'(cbi_pkg::QDEPTH), "queue overfilled")
    `CBI_ASSERT_IMPLIES(a_q_no_overflow, push, !full || pop, "push into full queue")
    `CBI_ASSERT_IMPLIES(a_q_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

>>> hdl/cbi_back.sv
// ---------------------------------------------------------------------------
// cbi_back
// Executes queued words: grid writes, four-corner reads from replicated
// grid copies, and the bilinear weighting, rounding and saturation.
// ---------------------------------------------------------------------------
`include "tx_cal_bilinear_interp_defines.svh"

module cbi_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  cbi_pkg::entry_t                q_entry,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cbi_pkg::DAC_W-1:0]      dac_att,
    output logic [cbi_pkg::RES_W-1:0]      bb_att_x100,
    output logic [cbi_pkg::RES_W-1:0]      ofs_corr
);

    localparam int W = cbi_pkg::WORD_WIDTH;

    // grid copies, one per corner so all four are read in the same cycle
    logic [W-1:0] att_mem [4][cbi_pkg::GRID_SIZE];
    logic [W-1:0] off_mem [4][cbi_pkg::GRID_SIZE];

    logic en, wr_att, wr_off, rd_go;
    logic [cbi_pkg::ADDR_W-1:0] raddr [4];
    logic [cbi_pkg::TF_W-1:0]   wf_lo;
    logic [cbi_pkg::S_W-1:0]    ws_hi;
    logic [15:0]                wgt [4];

    // pipeline registers
    logic                       p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic                       out_valid_reg;
    logic [W-1:0]               p1_att_reg [4];
    logic [W-1:0]               p1_off_reg [4];
    logic [cbi_pkg::WGT_W-1:0]  p1_w_reg [4];
    logic signed [31:0]         p2_pa_reg [4];
    logic signed [38:0]         p2_po_reg [4];
    logic [cbi_pkg::DAC_W-1:0]  p2_dac_reg, p3_dac_reg, p4_dac_reg;
    logic [cbi_pkg::RES_W-1:0]  p3_att_reg, p4_att_reg;
    logic [cbi_pkg::ODIV_U_W-1:0] p3_u_reg;
    logic                       p3_hi_reg, p3_lo_reg, p4_hi_reg, p4_lo_reg;
    logic [cbi_pkg::ODIV_P_W-1:0] p4_prod_reg;
    logic [cbi_pkg::DAC_W-1:0]  out_dac_reg;
    logic [cbi_pkg::RES_W-1:0]  out_att_reg, out_off_reg;

    // P2 combinational
    logic signed [16:0]         frac [4];
    logic [W-1:0]               neg  [4];
    logic signed [W-1:0]        offm [4];
    logic signed [31:0]         pa   [4];
    logic signed [38:0]         po   [4];
    logic signed [W:0]          att0x, mag;
    logic [W:0]                 mag_sh;
    logic [cbi_pkg::DAC_W-1:0]  dac;

    // P3 combinational
    logic signed [33:0]         n_att, ra;
    logic signed [40:0]         n_off, mo, ub;
    logic [cbi_pkg::RES_W-1:0]  att_sat;

    // output combinational
    logic [cbi_pkg::RES_W-1:0]  qv, off_res;

    assign en      = !out_valid_reg || m_ready;
    assign q_pop   = q_valid && en;
    assign wr_att  = q_pop && (q_entry.kind == cbi_pkg::KIND_WR_ATT);
    assign wr_off  = q_pop && (q_entry.kind == cbi_pkg::KIND_WR_OFF);
    assign rd_go   = q_pop && (q_entry.kind == cbi_pkg::KIND_LOOKUP);

    // corner addresses and weights
    always_comb begin
        raddr[0] = q_entry.addr;
        raddr[1] = q_entry.addr + cbi_pkg::ADDR_W'(1);
        raddr[2] = q_entry.addr + cbi_pkg::ADDR_W'(cbi_pkg::FREQ_COLS);
        raddr[3] = q_entry.addr + cbi_pkg::ADDR_W'(cbi_pkg::FREQ_COLS + 1);
        wf_lo    = cbi_pkg::TF_W'(cbi_pkg::FREQ_STEP) - q_entry.tf;
        ws_hi    = cbi_pkg::S_W'(256) - q_entry.s;
        wgt[0]   = 16'(wf_lo) * 16'(ws_hi);
        wgt[1]   = 16'(q_entry.tf) * 16'(ws_hi);
        wgt[2]   = 16'(wf_lo) * 16'(q_entry.s);
        wgt[3]   = 16'(q_entry.tf) * 16'(q_entry.s);
    end

    // grid memories: write on write words, registered corner reads
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 4; k++) begin
            if (wr_att) begin
                att_mem[k][q_entry.addr] <= q_entry.value;
            end
            if (wr_off) begin
                off_mem[k][q_entry.addr] <= q_entry.value;
            end
            if (rd_go) begin
                p1_att_reg[k] <= att_mem[k][raddr[k]];
                p1_off_reg[k] <= off_mem[k][raddr[k]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_go) begin
            for (int k = 0; k < 4; k++) begin
                p1_w_reg[k] <= wgt[k][cbi_pkg::WGT_W-1:0];
            end
        end
    end

    // signed fractions, offset masking, corner products, converter attenuation
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            neg[k] = -p1_att_reg[k];
            if (p1_att_reg[k][W-1]) begin
                frac[k] = -$signed({1'b0, neg[k][15:0]});
            end else begin
                frac[k] = $signed({1'b0, p1_att_reg[k][15:0]});
            end
            offm[k] = (p1_att_reg[k] == '0) ? '0 : $signed(p1_off_reg[k]);
            pa[k]   = 32'(frac[k]) * 32'($signed({1'b0, p1_w_reg[k]}));
            po[k]   = 39'(offm[k]) * 39'($signed({1'b0, p1_w_reg[k]}));
        end
        att0x  = $signed({p1_att_reg[0][W-1], p1_att_reg[0]});
        mag    = (att0x < 0) ? -att0x : att0x;
        mag_sh = $unsigned(mag) >> 16;
        dac    = (mag_sh > (W+1)'(255)) ? 8'hFF : mag_sh[cbi_pkg::DAC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                p2_pa_reg[k] <= pa[k];
                p2_po_reg[k] <= po[k];
            end
            p2_dac_reg <= dac;
        end
    end

    // sums, rounding; offset divided by 256 here and by 50 below
    always_comb begin
        n_att = 34'(p2_pa_reg[0]) + 34'(p2_pa_reg[1]) + 34'(p2_pa_reg[2]) + 34'(p2_pa_reg[3]);
        n_off = 41'(p2_po_reg[0]) + 41'(p2_po_reg[1]) + 41'(p2_po_reg[2]) + 41'(p2_po_reg[3]);
        ra    = (n_att + 34'sd64) >>> 7;
        if (ra > 34'sd8388607) begin
            att_sat = 24'h7FFFFF;
        end else if (ra < -34'sd8388608) begin
            att_sat = 24'h800000;
        end else begin
            att_sat = ra[cbi_pkg::RES_W-1:0];
        end
        mo = (n_off + 41'sd6400) >>> 8;
        ub = mo + cbi_pkg::ODIV_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_att_reg <= att_sat;
            p3_hi_reg  <= (mo >= cbi_pkg::ODIV_BIAS);
            p3_lo_reg  <= (mo < -cbi_pkg::ODIV_BIAS);
            p3_u_reg   <= ub[cbi_pkg::ODIV_U_W-1:0];
            p3_dac_reg <= p2_dac_reg;
        end
    end

    // reciprocal multiply for the divide by 50
    always_ff @(posedge aclk) begin
        if (en) begin
            p4_prod_reg <= cbi_pkg::ODIV_P_W'(p3_u_reg) * cbi_pkg::ODIV_P_W'(cbi_pkg::ODIV_MULT);
            p4_hi_reg   <= p3_hi_reg;
            p4_lo_reg   <= p3_lo_reg;
            p4_att_reg  <= p3_att_reg;
            p4_dac_reg  <= p3_dac_reg;
        end
    end

    // remove the bias and saturate
    always_comb begin
        qv = p4_prod_reg[cbi_pkg::ODIV_SHIFT +: cbi_pkg::RES_W];
        if (p4_hi_reg) begin
            off_res = 24'h7FFFFF;
        end else if (p4_lo_reg) begin
            off_res = 24'h800000;
        end else begin
            off_res = {~qv[cbi_pkg::RES_W-1], qv[cbi_pkg::RES_W-2:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en && p4_valid_reg) begin
            out_dac_reg <= p4_dac_reg;
            out_att_reg <= p4_att_reg;
            out_off_reg <= off_res;
        end
    end

    // stage valids, whole pipe holds while the output word waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= rd_go;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign dac_att     = out_dac_reg;
    assign bb_att_x100 = out_att_reg;
    assign ofs_corr    = out_off_reg;

    `CBI_ASSERT_NEXT(a_b_stall_holds, !en,
        $stable({p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg}),
        "pipe moved while stalled")
    `CBI_ASSERT_NEXT(a_b_write_no_result, wr_att || wr_off, !p1_valid_reg,
        "write word entered the lookup pipe")
    `CBI_ASSERT_IMPLIES(a_b_sat_exclusive, p4_valid_reg, !(p4_hi_reg && p4_lo_reg),
        "offset saturates both ways")

endmodule

>>> hdl/tx_cal_bilinear_interp.sv
// ---------------------------------------------------------------------------
// tx_cal_bilinear_interp
// Transmit calibration grids with bilinear lookup over power and frequency.
// ---------------------------------------------------------------------------
// Path: a lookup word passes the front register, the queue, the corner read,
// products, sums, divide and output registers. Throughput: one word per cycle
// unless the output stalls, writes and lookups alike; the four-copy grid
// memories serve all four corners from one read port each every cycle.
// Reset: clears front, queue and pipe control; grid contents are kept and are
// undefined until written.
module tx_cal_bilinear_interp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[13:0], entry_value[37:14], freq_mhz[50:38], power_q8[66:51]
    input  logic [71:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dac_att[7:0], bb_att_x100[31:8], ofs_corr[55:32]
    output logic [55:0] m_axis_tdata
);

    logic            q_full, q_push, q_pop, q_valid;
    cbi_pkg::entry_t q_in, q_head;
    logic [cbi_pkg::DAC_W-1:0] dac_att;
    logic [cbi_pkg::RES_W-1:0] bb_att_x100, ofs_corr;

    // front: classify and compute grid position
    cbi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .op      (s_axis_tuser),
        .idx     (s_axis_tdata[13:0]),
        .val     (s_axis_tdata[37:14]),
        .freq    (s_axis_tdata[50:38]),
        .pwr     ($signed(s_axis_tdata[66:51])),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    cbi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    // back: grid access and interpolation
    cbi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_entry     (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .dac_att     (dac_att),
        .bb_att_x100 (bb_att_x100),
        .ofs_corr    (ofs_corr)
    );

    assign m_axis_tdata = {ofs_corr, bb_att_x100, dac_att};

endmodule

>>> tb/tx_cal_bilinear_interp_tb.sv
// ---------------------------------------------------------------------------
// tx_cal_bilinear_interp_tb
// Self-checking bench for the calibration lookup: loads the grid rows that
// lookups reach, runs directed and random table writes and lookups over the
// stream ports, predicts each lookup word locally and compares it.
// ---------------------------------------------------------------------------
module tx_cal_bilinear_interp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cbi_pkg::OP_W-1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    // middle row pair, loaded over the first few columns only
    localparam int MID_ROW  = 50;
    localparam int MID_COLS = 12;
    // power bands whose corner rows are all loaded, 1/256 dBm
    localparam int TOP_LO   = cbi_pkg::PWR_HI - 255;
    localparam int BOT_HI   = cbi_pkg::PWR_LO + 256;
    localparam int MID_HI   = cbi_pkg::PWR_LO + (cbi_pkg::POWER_ROWS - 1 - MID_ROW) * 256;
    localparam int MID_LO   = MID_HI - 255;
    localparam int MID_FMAX = cbi_pkg::FREQ_BASE + cbi_pkg::FREQ_STEP * (MID_COLS - 1) - 1;

    typedef struct {
        logic [cbi_pkg::OP_W-1:0] op;
        logic [13:0]     idx;
        logic [23:0]     val;
        logic [12:0]     freq;
        logic [15:0]     pwr;
    } req_t;

    typedef struct {
        logic [7:0]  dac;
        logic [23:0] bb;
        logic [23:0] off;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    req_t    pend_q[$];
    lookup_t lookup_q[$];
    req_t    cur_req;
    bit      s_acc = 0;
    int      s_idle_pct = 35;
    int      m_idle_pct = 62;
    int      errors = 0;
    int      n_lookups = 0;
    int      n_writes = 0;
    int      stall_cnt = 0;
    longint  att_mem[cbi_pkg::GRID_SIZE];
    longint  off_mem[cbi_pkg::GRID_SIZE];

    tx_cal_bilinear_interp dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint sfrac(longint w);
        if (w >= 0) return w & 64'hFFFF;
        return -((-w) & 64'hFFFF);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // rows loaded in full: the top two and the bottom two
    function automatic int full_row(int k);
        return (k < 2) ? k : cbi_pkg::POWER_ROWS - 4 + k;
    endfunction

    function automatic int loaded_index();
        int k;
        k = $urandom_range(3);
        return full_row(k) * cbi_pkg::FREQ_COLS + pick(0, cbi_pkg::FREQ_COLS - 1);
    endfunction

    // bilinear lookup over the local grid copies
    function automatic lookup_t interp_lookup(req_t r);
        lookup_t res;
        longint f, p, c, tf, pp, a, row, s, base, mag;
        longint wt[4], att[4], off[4];
        longint n_att, n_off;
        int pos;
        f = r.freq;
        p = $signed(r.pwr);
        if (f < cbi_pkg::FREQ_BASE) f = cbi_pkg::FREQ_BASE;
        if (f > cbi_pkg::FREQ_MAX) f = cbi_pkg::FREQ_MAX;
        c = (f - cbi_pkg::FREQ_BASE) / cbi_pkg::FREQ_STEP;
        if (c > cbi_pkg::FREQ_COLS - 2) c = cbi_pkg::FREQ_COLS - 2;
        tf = f - cbi_pkg::FREQ_BASE - cbi_pkg::FREQ_STEP * c;
        if (p < cbi_pkg::PWR_LO) p = cbi_pkg::PWR_LO;
        if (p > cbi_pkg::PWR_HI) p = cbi_pkg::PWR_HI;
        pp = p - cbi_pkg::PWR_LO;
        a = (pp + 255) / 256;
        if (a < 1) a = 1;
        row = (cbi_pkg::POWER_ROWS - 1) - a;
        s = a * 256 - pp;
        base = row * cbi_pkg::FREQ_COLS + c;
        wt[0] = (cbi_pkg::FREQ_STEP - tf) * (256 - s);
        wt[1] = tf * (256 - s);
        wt[2] = (cbi_pkg::FREQ_STEP - tf) * s;
        wt[3] = tf * s;
        n_att = 0;
        n_off = 0;
        for (int k = 0; k < 4; k++) begin
            pos = int'(base + (k % 2) + ((k / 2) * cbi_pkg::FREQ_COLS));
            att[k] = att_mem[pos];
            off[k] = (att[k] == 0) ? 0 : off_mem[pos];
            n_att += sfrac(att[k]) * wt[k];
            n_off += off[k] * wt[k];
        end
        mag = att[0] < 0 ? -att[0] : att[0];
        mag = mag >> 16;
        res.dac = (mag > 255) ? 8'hFF : mag[7:0];
        res.bb  = clip24(fdiv(n_att + 64, 128));
        res.off = clip24(fdiv(n_off + 6400, 12800));
        return res;
    endfunction

    function automatic logic [23:0] rand_word();
        int k;
        k = $urandom_range(99);
        if (k < 10) return 24'h0;
        if (k < 13) return 24'h800000;
        if (k < 16) return 24'h7FFFFF;
        if (k < 20) return {8'hFF, 16'($urandom_range(65535))};
        return 24'($urandom);
    endfunction

    task automatic add_req(logic [cbi_pkg::OP_W-1:0] op, int idx, logic [23:0] val,
                           int freq, int pwr);
        req_t r;
        r.op = op;
        r.idx = 14'(idx);
        r.val = val;
        r.freq = 13'(freq);
        r.pwr = 16'(pwr);
        pend_q.push_back(r);
    endtask

    // lookup whose four corners all lie in loaded rows
    task automatic add_lookup();
        int band, f, p;
        band = $urandom_range(4);
        f = pick(0, 8191);
        if (band == 0) begin
            p = pick(TOP_LO, cbi_pkg::PWR_HI);
        end else if (band == 1) begin
            p = pick(cbi_pkg::PWR_HI + 1, 32767);
        end else if (band == 2) begin
            p = pick(cbi_pkg::PWR_LO, BOT_HI);
        end else if (band == 3) begin
            p = pick(-32768, cbi_pkg::PWR_LO - 1);
        end else begin
            p = pick(MID_LO, MID_HI);
            f = pick(0, MID_FMAX);
        end
        add_req(cbi_pkg::OP_LOOKUP, pick(0, 16383), 24'($urandom), f, p);
    endtask

    task automatic add_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 55)
                add_lookup();
            else if (k < 75)
                add_req(k < 65 ? cbi_pkg::OP_WR_ATT : cbi_pkg::OP_WR_OFF, loaded_index(),
                        rand_word(), pick(0, 8191), pick(-32768, 32767));
            else if (k < 85)
                add_req(k < 80 ? cbi_pkg::OP_WR_ATT : cbi_pkg::OP_WR_OFF,
                        pick(0, cbi_pkg::GRID_SIZE - 1), rand_word(), pick(0, 8191),
                        pick(-32768, 32767));
            else if (k < 93)
                add_req(cbi_pkg::OP_W'($urandom_range(1)), pick(cbi_pkg::GRID_SIZE, 16383),
                        24'($urandom), pick(0, 8191), pick(-32768, 32767));
            else
                add_req(OP_NONE, pick(0, 16383), 24'($urandom), pick(0, 8191),
                        pick(-32768, 32767));
        end
    endtask

    // let the pending words and all lookup results drain, then settle
    task automatic drain();
        wait (pend_q.size() == 0 && !s_axis_tvalid && lookup_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver: new word on the falling edge once the previous one is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_acc) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                    cur_req = pend_q.pop_front();
                    s_axis_tdata  <= {5'b0, cur_req.pwr, cur_req.freq, cur_req.val,
                                      cur_req.idx};
                    s_axis_tuser  <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // input side: update grid copies, queue expected lookup words
    always @(posedge aclk) begin
        s_acc = aresetn && s_axis_tvalid && s_axis_tready;
        if (s_acc) begin
            if ((cur_req.op == cbi_pkg::OP_WR_ATT || cur_req.op == cbi_pkg::OP_WR_OFF)
                    && cur_req.idx < cbi_pkg::GRID_SIZE) begin
                if (cur_req.op == cbi_pkg::OP_WR_ATT) att_mem[cur_req.idx] = $signed(cur_req.val);
                else off_mem[cur_req.idx] = $signed(cur_req.val);
                n_writes++;
            end else if (cur_req.op == cbi_pkg::OP_LOOKUP) begin
                lookup_q.push_back(interp_lookup(cur_req));
                n_lookups++;
            end
        end
    end

    // result side: compare against the oldest expected word
    always @(posedge aclk) begin
        lookup_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.dac = m_axis_tdata[7:0];
            got.bb  = m_axis_tdata[31:8];
            got.off = m_axis_tdata[55:32];
            if (lookup_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h", $time, m_axis_tdata);
            end else begin
                want = lookup_q.pop_front();
                if (got.dac !== want.dac) begin
                    errors++;
                    $display("%0t: dac_att exp %0d got %0d", $time, want.dac, got.dac);
                end
                if (got.bb !== want.bb) begin
                    errors++;
                    $display("%0t: bb_att_x100 exp %h got %h", $time, want.bb, got.bb);
                end
                if (got.off !== want.off) begin
                    errors++;
                    $display("%0t: ofs_corr exp %h got %h", $time, want.off, got.off);
                end
            end
        end
    end

    // watchdog: cycles without any handshake while work is outstanding
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (pend_q.size() == 0 && lookup_q.size() == 0 && !s_axis_tvalid))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, %0d results outstanding", $time, lookup_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // load every entry that a lookup below can reach, in both grids
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < cbi_pkg::FREQ_COLS; c++) begin
                add_req(cbi_pkg::OP_WR_ATT, full_row(k) * cbi_pkg::FREQ_COLS + c,
                        rand_word(), 0, 0);
                add_req(cbi_pkg::OP_WR_OFF, full_row(k) * cbi_pkg::FREQ_COLS + c,
                        rand_word(), 0, 0);
            end
        end
        for (int r = MID_ROW; r <= MID_ROW + 1; r++) begin
            for (int c = 0; c < MID_COLS; c++) begin
                add_req(cbi_pkg::OP_WR_ATT, r * cbi_pkg::FREQ_COLS + c, rand_word(), 0, 0);
                add_req(cbi_pkg::OP_WR_OFF, r * cbi_pkg::FREQ_COLS + c, rand_word(), 0, 0);
            end
        end

        // directed: axis edges, clamping, ceiling row, odd operations
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 0, -32768);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 8191, 32767);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, cbi_pkg::FREQ_BASE, cbi_pkg::PWR_HI);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, cbi_pkg::FREQ_MAX, cbi_pkg::PWR_LO);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, cbi_pkg::FREQ_MAX - 1, cbi_pkg::PWR_LO + 1);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, cbi_pkg::FREQ_MAX + 1, cbi_pkg::PWR_HI - 1);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 199, BOT_HI);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 225, TOP_LO);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 199, MID_HI);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 249, MID_LO);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 700, -9000);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 3125, -21600);
        add_req(cbi_pkg::OP_WR_ATT, 0, 24'h800000, 0, 0);
        add_req(cbi_pkg::OP_WR_ATT, 1, 24'h000000, 0, 0);
        add_req(cbi_pkg::OP_WR_ATT, cbi_pkg::FREQ_COLS, 24'h7FFFFF, 0, 0);
        add_req(cbi_pkg::OP_WR_OFF, 1, 24'h7FFFFF, 0, 0);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 230, cbi_pkg::PWR_HI - 100);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 200, cbi_pkg::PWR_HI);
        add_req(cbi_pkg::OP_WR_ATT, cbi_pkg::GRID_SIZE, 24'h123456, 0, 0);
        add_req(cbi_pkg::OP_WR_OFF, 16383, 24'hFFFFFF, 0, 0);
        add_req(OP_NONE, 0, 24'h0, 300, 0);
        add_req(cbi_pkg::OP_LOOKUP, 0, 24'h0, 200, cbi_pkg::PWR_HI);
        add_random(300);
        drain();

        s_idle_pct = 62;
        m_idle_pct = 35;
        add_random(300);
        drain();

        s_idle_pct = 0;
        m_idle_pct = 0;
        add_random(295);
        drain();

        $display("covered %0d table writes and %0d lookups over three idle profiles",
                 n_writes, n_lookups);
        $display("top, bottom and middle power bands; axis clamps, edge pairs, op codes");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/cbi_pkg.sv
hdl/cbi_front.sv
hdl/cbi_queue.sv
hdl/cbi_back.sv
hdl/tx_cal_bilinear_interp.sv
tb/tx_cal_bilinear_interp_tb.sv
